[rtl/core/sri_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted record insertion package
// Shared widths, record and command types, and status and operation codes.
// ---------------------------------------------------------------------------
package sri_pkg;

  localparam int KEY_W       = 64;
  localparam int TAG_W       = 16;
  localparam int SCORE_W     = 16;
  localparam int HELD_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 104;

  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_KEY_CHARS   = 8;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic drn;
    rec_t rec;
  } cmd_t;

endpackage

[rtl/core/sorted_record_insertion_unit.sv]
// A result appears in the output register in the cycle after its transfer.
// One item per cycle unless the output stalls; every cell compares the new key
// at once and the whole chain shifts in the same cycle, so no step iterates.
// Reset clears the record count and the output valid; the slots keep old data,
// which is never read because the count marks them unused.
// ---------------------------------------------------------------------------
// Sorted record insertion unit
// Chain of cells holding records in ascending key order, with stable insert
// and drain of the smallest record.
// ---------------------------------------------------------------------------
module sorted_record_insertion_unit #(
  parameter int TABLE_DEPTH = sri_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_CHARS   = sri_pkg::DEF_KEY_CHARS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // surname_key[63:0], record_tag[79:64], score_tenths[95:80]
  input  logic [sri_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_key[63:0], out_tag[79:64], out_score[95:80], held_count[103:96]
  output logic [sri_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [sri_pkg::STATUS_W-1:0]   m_tuser,
  // last_record
  output logic                           m_tlast
);
  import sri_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [KEY_W-1:0] KeyMask = {KEY_W{1'b1}} << (8 * (8 - KEY_CHARS));

  logic             s_fire;
  logic             is_drain;
  logic             full;
  logic             empty;
  cmd_t             cmd;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  rec_t             cell_rec [TABLE_DEPTH];
  logic             cell_le  [TABLE_DEPTH];

  status_t          res_status;
  rec_t             res_rec;
  logic             res_last;

  // Output register
  rec_t             o_rec;
  status_t          o_status;
  logic             o_last;
  logic [HELD_W-1:0] o_held;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign is_drain = (op_t'(s_tuser) == OP_DRAIN);
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign empty    = (count == '0);

  // Command to the chain, key narrowed to its kept characters
  always_comb begin
    cmd.ins       = s_fire && !is_drain && !full;
    cmd.drn       = s_fire && is_drain && !empty;
    cmd.rec.key   = s_tdata[KEY_W-1:0] & KeyMask;
    cmd.rec.tag   = s_tdata[KEY_W +: TAG_W];
    cmd.rec.score = s_tdata[KEY_W+TAG_W +: SCORE_W];
  end

  // Chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t left_rec;
    logic left_le;
    rec_t right_rec;

    if (i == 0) begin : g_head
      assign left_rec = '0;
      assign left_le  = 1'b1;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign left_le  = cell_le[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_mid
      assign right_rec = cell_rec[i+1];
    end

    sri_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .left_rec  (left_rec),
      .left_le   (left_le),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .le        (cell_le[i])
    );
  end

  // Result of the current transfer
  always_comb begin
    res_status = ST_OK;
    res_rec    = '0;
    res_last   = 1'b0;
    count_next = count;
    if (!is_drain) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_rec    = cell_rec[0];
        count_next = count - CNT_W'(1);
        res_last   = (count == CNT_W'(1));
      end
    end
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        count <= count_next;
      end
      if (s_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      o_rec    <= res_rec;
      o_status <= res_status;
      o_last   <= res_last;
      o_held   <= HELD_W'(count_next);
    end
  end

  assign m_tdata = {o_held, o_rec.score, o_rec.tag, o_rec.key};
  assign m_tuser = o_status;
  assign m_tlast = o_last;

  // Count stays within the chain length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  // A successful insert grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  // Head two records are in order
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> cell_rec[0].key <= cell_rec[1].key)
    else $error("chain head out of order");

  // Non-ok results carry no record
  a_no_rec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_status != ST_OK) |-> (o_rec == '0) && !o_last)
    else $error("record fields set on failed step");

endmodule

[rtl/core/sri_cell.sv]
// ---------------------------------------------------------------------------
// Sorted record cell
// One slot of the sorted chain: keeps, takes the new record, shifts from the
// left neighbour on insert, or from the right neighbour on drain.
// ---------------------------------------------------------------------------
module sri_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  logic              clk,
  input  sri_pkg::cmd_t     cmd,
  input  logic [CNT_W-1:0]  count,
  input  sri_pkg::rec_t     left_rec,
  input  logic              left_le,
  input  sri_pkg::rec_t     right_rec,
  output sri_pkg::rec_t     rec,
  output logic              le
);
  import sri_pkg::*;

  logic in_use;

  // Slot holds a record and its key does not exceed the new key
  assign in_use = (CNT_W'(IDX) < count);
  assign le     = in_use && (rec.key <= cmd.rec.key);

  // Stable insert keeps equal keys ahead of the new record
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!le) begin
        rec <= left_le ? cmd.rec : left_rec;
      end
    end else if (cmd.drn) begin
      rec <= right_rec;
    end
  end

endmodule

[verif/tb_sorted_record_insertion_unit.sv]
// ---------------------------------------------------------------------------
// Testbench for the sorted record insertion unit
// Drives insert and drain commands over the input stream and checks every
// output transfer against a behavioural table kept in ascending key order.
// Covers empty drains, stable inserts of equal keys, full-table drops,
// random mixes with bursty idling on both sides, and a long output hold-off.
// ---------------------------------------------------------------------------
module tb_sorted_record_insertion_unit;
  import sri_pkg::*;

  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int KEY_CHARS    = DEF_KEY_CHARS;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  // One predicted output transfer
  typedef struct {
    status_t           status;
    rec_t              rec;
    logic              last;
    logic [HELD_W-1:0] held;
  } table_reply_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;

  // Behavioural table, ascending key, and replies still owed by the block
  rec_t         model_table[$];
  table_reply_t replies_due[$];

  // Idling controls
  bit gaps_on;
  bit stalls_on;
  bit hold_off_req;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned reply_count;
  int unsigned insert_count;
  int unsigned drain_count;
  int unsigned full_drops;
  int unsigned empty_drains;
  int unsigned peak_fill;

  logic [KEY_W-1:0] key_pool[8];

  sorted_record_insertion_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS  (KEY_CHARS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Keep only the top KEY_CHARS bytes of a key
  function automatic logic [KEY_W-1:0] narrowed(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] low_mask;
    low_mask = {KEY_W{1'b1}} >> (8 * KEY_CHARS);
    return key & ~low_mask;
  endfunction

  // Random 16-bit field value
  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Apply one command to the behavioural table and return the reply it causes
  function automatic table_reply_t table_step(input op_t op, input logic [KEY_W-1:0] key,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [SCORE_W-1:0] score);
    table_reply_t r;
    rec_t         nr;
    int           pos;
    r.status = ST_OK;
    r.rec    = '0;
    r.last   = 1'b0;
    if (op == OP_INSERT) begin
      if (model_table.size() >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        nr.key   = narrowed(key);
        nr.tag   = tag;
        nr.score = score;
        // stable: goes after every key that is equal or smaller
        pos = 0;
        while (pos < model_table.size() && model_table[pos].key <= nr.key) pos++;
        model_table.insert(pos, nr);
      end
    end else begin
      if (model_table.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.rec = model_table.pop_front();
        r.last = (model_table.size() == 0);
      end
    end
    r.held = HELD_W'(model_table.size());
    return r;
  endfunction

  // Random key: duplicates from a pool, packed letters, extremes or raw bits
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               len;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = key_pool[$urandom_range(0, 7)];
      1: begin
        len = $urandom_range(1, 8);
        for (int c = 0; c < len; c++) k[63 - 8*c -: 8] = 8'(65 + $urandom_range(0, 25));
      end
      2: k = $urandom_range(0, 1) ? '0 : '1;
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // Offer one command and record the reply it is owed once it transfers
  task automatic send_item(input op_t op, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input logic [SCORE_W-1:0] score);
    table_reply_t r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tdata  = {score, tag, key};
    s_tuser  = op;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = table_step(op, key, tag, score);
    replies_due.push_back(r);
    if (op == OP_INSERT) insert_count++;
    else drain_count++;
    if (r.held > peak_fill) peak_fill = r.held;
    @(negedge clk);
  endtask

  task automatic send_random_item(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct)
      send_item(OP_INSERT, pick_key(), rand16(), rand16());
    else
      send_item(OP_DRAIN, {$urandom, $urandom}, rand16(), rand16());
  endtask

  // Output side: random stalls and the long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
        m_tready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Compare every output transfer with the oldest owed reply
  initial begin
    table_reply_t e;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        reply_count++;
        if (m_tuser == ST_FULL) full_drops++;
        if (m_tuser == ST_EMPTY) empty_drains++;
        if (replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: reply with none owed: status %0d key %h", m_tuser,
                     m_tdata[63:0]);
        end else begin
          e = replies_due.pop_front();
          if (m_tuser !== e.status || m_tdata[63:0] !== e.rec.key ||
              m_tdata[79:64] !== e.rec.tag || m_tdata[95:80] !== e.rec.score ||
              m_tdata[103:96] !== e.held || m_tlast !== e.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ERROR at cycle %0d, reply %0d", cycle_count, reply_count);
              $display("  expected status %0d key %h tag %h score %h last %0d held %0d",
                       e.status, e.rec.key, e.rec.tag, e.rec.score, e.last, e.held);
              $display("  actual   status %0d key %h tag %h score %h last %0d held %0d",
                       m_tuser, m_tdata[63:0], m_tdata[79:64], m_tdata[95:80], m_tlast,
                       m_tdata[103:96]);
            end
          end
        end
      end
    end
  end

  // Empty drains, field extremes, equal keys kept in arrival order
  task automatic test_directed();
    send_item(OP_DRAIN, '1, 16'hFFFF, 16'hFFFF);
    send_item(OP_INSERT, '1, 16'hFFFF, 16'hFFFF);
    send_item(OP_INSERT, '0, 16'h0000, 16'h0000);
    send_item(OP_INSERT, 64'h534D_4954_4800_0000, 16'h0001, 16'd955);
    send_item(OP_INSERT, 64'h534D_4954_4800_0000, 16'h0002, 16'd100);
    send_item(OP_INSERT, 64'h534D_4954_4800_0000, 16'h0003, 16'd21);
    send_item(OP_INSERT, 64'h4142_4300_0000_0000, 16'hAAAA, 16'h5555);
    send_item(OP_INSERT, 64'h4142_4341_0000_0000, 16'h5555, 16'hAAAA);
    send_item(OP_INSERT, '1, 16'h0000, 16'hFFFF);
    send_item(OP_INSERT, '0, 16'hFFFF, 16'h0000);
    repeat (9) send_item(OP_DRAIN, {$urandom, $urandom}, rand16(), rand16());
    send_item(OP_DRAIN, '0, 16'h0000, 16'h0000);
    send_item(OP_INSERT, 64'h8000_0000_0000_0001, 16'h1234, 16'h4321);
    send_item(OP_DRAIN, '0, 16'h0000, 16'h0000);
  endtask

  // Fill past capacity behind a long output hold-off, then drain past empty
  task automatic test_fill_and_overflow();
    while (model_table.size() > 0) send_item(OP_DRAIN, '0, '0, '0);
    hold_off_req = 1'b1;
    repeat (TABLE_DEPTH + 4)
      send_item(OP_INSERT, pick_key(), rand16(), rand16());
    repeat (TABLE_DEPTH + 4)
      send_item(OP_DRAIN, {$urandom, $urandom}, rand16(), rand16());
  endtask

  // Random mix in phases that push the fill level up and down
  task automatic test_random_mix(input int count);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 20;
          1: insert_pct = 50;
          2: insert_pct = 80;
          default: insert_pct = 97;
        endcase
      end
      send_random_item(insert_pct);
    end
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_back_to_back(input int count);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < count; i++) send_random_item((i < count / 2) ? 70 : 35);
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_INSERT;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_off_req   = 1'b0;
    mismatch_count = 0;
    reply_count    = 0;
    insert_count   = 0;
    drain_count    = 0;
    full_drops     = 0;
    empty_drains   = 0;
    peak_fill      = 0;
    for (int p = 0; p < 8; p++) key_pool[p] = {$urandom, $urandom} & {8{8'hE7}};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_and_overflow();
    test_random_mix(450);
    test_back_to_back(150);
    s_tvalid = 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d inserts and %0d drains; checked %0d replies", insert_count,
             drain_count, reply_count);
    $display("Full-table drops %0d, empty drains %0d, peak fill %0d of %0d",
             full_drops, empty_drains, peak_fill, TABLE_DEPTH);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", mismatch_count,
               replies_due.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sorted_record_insertion_unit.f]
rtl/core/sri_pkg.sv
rtl/core/sri_cell.sv
rtl/core/sorted_record_insertion_unit.sv
verif/tb_sorted_record_insertion_unit.sv
